// ===== sv/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg: shared definitions for the first-fit heap allocator
// Sizes, block record layout, status codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_BYTES   = 67108864;
  localparam int HEADER_BYTES = 12;
  localparam int MAX_BLOCKS   = 256;
  localparam int ALIGN_BYTES  = 8;

  localparam int OFS_W  = 27;
  localparam int WANT_W = OFS_W + 1;
  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int LINK_W = IDX_W + 1;

  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(MAX_BLOCKS);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [OFS_W-1:0]  start;
    logic [OFS_W-1:0]  len;
    logic              is_free;
    logic [LINK_W-1:0] link;
  } rec_t;

  localparam rec_t RESET_REC = '{
    start:   '0,
    len:     OFS_W'(HEAP_BYTES - HEADER_BYTES),
    is_free: 1'b1,
    link:    END_MARK
  };

  // controller to datapath
  typedef struct packed {
    logic start;     // item accepted, latch request and read entry 0
    logic step;      // follow the link to the next block
    logic commit;    // matching block found, update table and result
    logic miss;      // walk ended without a match
    logic write_new; // write the split-off block
    logic load_out;  // move result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic stop;
    logic split;
  } sts_t;

endpackage

// ===== sv/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl: allocator sequencer
// Accepts an item, steps the block walk, sequences write-back and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            action,
  input  logic            null_free,
  output logic            out_valid,
  input  logic            out_stall,
  input  ffha_pkg::sts_t  sts,
  output ffha_pkg::cmd_t  cmd
);
  import ffha_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_SPLIT, S_DONE} state_t;

  state_t state;
  logic   take_in;
  logic   slot_free;

  assign in_stall  = (state != S_IDLE);
  assign take_in   = in_valid && (state == S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.start = take_in;
      end
      S_WALK: begin
        if (sts.hit) begin
          cmd.commit = 1'b1;
        end else if (sts.stop) begin
          cmd.miss = 1'b1;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SPLIT: begin
        cmd.write_new = 1'b1;
      end
      S_DONE: begin
        cmd.load_out = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take_in) begin
            // null free needs no walk
            state <= (action == ACT_FREE && null_free) ? S_DONE : S_WALK;
          end
        end
        S_WALK: begin
          if (sts.hit) begin
            state <= sts.split ? S_SPLIT : S_DONE;
          end else if (sts.stop) begin
            state <= S_DONE;
          end
        end
        S_SPLIT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/ffha_dpath.sv =====
// ----------------------------------------------------------------------------
// ffha_dpath: block table and walk datapath
// Holds the block table memory, the walk pointer, the free byte total and
// the result and output registers.
// ----------------------------------------------------------------------------
module ffha_dpath (
  input  logic                    clk,
  input  logic                    rst,
  input  ffha_pkg::cmd_t          cmd,
  output ffha_pkg::sts_t          sts,
  input  logic                    action,
  input  logic [ffha_pkg::OFS_W-1:0] request_bytes,
  input  logic [ffha_pkg::OFS_W-1:0] release_offset,
  output logic                    null_free,
  output logic [1:0]              status,
  output logic [ffha_pkg::OFS_W-1:0] granted_offset,
  output logic [ffha_pkg::OFS_W-1:0] free_bytes
);
  import ffha_pkg::*;

  rec_t mem [MAX_BLOCKS];
  rec_t rdata_raw;
  logic rd_default;
  logic init0;

  logic              act;
  logic [WANT_W-1:0] want;
  logic [OFS_W-1:0]  off;
  logic [LINK_W-1:0] cur;
  logic [LINK_W-1:0] visits;
  logic [LINK_W-1:0] blocks_used;
  logic [OFS_W-1:0]  free_total;
  rec_t              nrec;
  logic [IDX_W-1:0]  nb;
  logic [1:0]        res_status;
  logic [OFS_W-1:0]  res_offset;

  rec_t              rec;
  logic [IDX_W-1:0]  raddr;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  rec_t              wdata;
  logic              hit_alloc;
  logic              hit_free;
  logic              split_due;
  logic              can_split;
  logic [WANT_W-1:0] want_next;

  assign null_free = (release_offset == '0);
  assign want_next = (WANT_W'(request_bytes) + WANT_W'(ALIGN_BYTES - 1))
                     & ~WANT_W'(ALIGN_BYTES - 1);

  // entry 0 reads as its reset value until first written
  assign rec = rd_default ? RESET_REC : rdata_raw;

  assign hit_alloc = rec.is_free && ({1'b0, rec.len} >= want);
  assign hit_free  = ({1'b0, rec.start} + WANT_W'(HEADER_BYTES)) == {1'b0, off};
  assign split_due = {2'b0, rec.len} >
                     ({1'b0, want} + (WANT_W + 1)'(HEADER_BYTES + ALIGN_BYTES));
  assign can_split = blocks_used < LINK_W'(MAX_BLOCKS);

  assign sts.hit   = (act == ACT_FREE) ? hit_free : hit_alloc;
  assign sts.stop  = (rec.link == END_MARK) || (rec.link >= blocks_used) ||
                     (visits == LINK_W'(MAX_BLOCKS - 1));
  assign sts.split = (act == ACT_ALLOC) && split_due && can_split;

  always_comb begin
    raddr = '0;
    if (cmd.step) begin
      raddr = rec.link[IDX_W-1:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur[IDX_W-1:0];
    wdata = rec;
    if (cmd.commit) begin
      if (act == ACT_FREE) begin
        we            = 1'b1;
        wdata.is_free = 1'b1;
      end else begin
        we            = 1'b1;
        wdata.is_free = 1'b0;
        if (split_due && can_split) begin
          wdata.len  = want[OFS_W-1:0];
          wdata.link = blocks_used;
        end
      end
    end else if (cmd.write_new) begin
      we    = 1'b1;
      waddr = nb;
      wdata = nrec;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_raw <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init0       <= 1'b0;
      rd_default  <= 1'b0;
      blocks_used <= LINK_W'(1);
      free_total  <= OFS_W'(HEAP_BYTES - HEADER_BYTES);
    end else begin
      rd_default <= (raddr == '0) && !(init0 || (we && waddr == '0));
      if (we && waddr == '0) begin
        init0 <= 1'b1;
      end
      if (cmd.commit) begin
        if (act == ACT_FREE) begin
          if (!rec.is_free) begin
            free_total <= free_total + rec.len;
          end
        end else if (split_due && can_split) begin
          blocks_used <= blocks_used + LINK_W'(1);
          free_total  <= free_total - want[OFS_W-1:0];
        end else begin
          free_total <= free_total - rec.len;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act        <= action;
      want       <= want_next;
      off        <= release_offset;
      cur        <= '0;
      visits     <= '0;
      res_status <= ST_OK;
      res_offset <= '0;
    end
    if (cmd.step) begin
      cur    <= rec.link;
      visits <= visits + LINK_W'(1);
    end
    if (cmd.commit) begin
      if (act == ACT_FREE) begin
        res_status <= ST_OK;
        res_offset <= '0;
      end else begin
        res_status <= (split_due && !can_split) ? ST_FULL : ST_OK;
        res_offset <= rec.start + OFS_W'(HEADER_BYTES);
      end
      nb           <= blocks_used[IDX_W-1:0];
      nrec.start   <= rec.start + OFS_W'(HEADER_BYTES) + want[OFS_W-1:0];
      nrec.len     <= rec.len - want[OFS_W-1:0] - OFS_W'(HEADER_BYTES);
      nrec.is_free <= 1'b1;
      nrec.link    <= rec.link;
    end
    if (cmd.miss) begin
      res_status <= (act == ACT_FREE) ? ST_UNKNOWN : ST_NO_FIT;
      res_offset <= '0;
    end
    if (cmd.load_out) begin
      status         <= res_status;
      granted_offset <= res_offset;
      free_bytes     <= free_total;
    end
  end

endmodule

// ===== sv/first_fit_heap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit: first-fit heap allocator
// Allocates and frees blocks of a 64 MiB heap through an address-ordered
// block table of 256 entries, reporting the free byte total with each result.
// ----------------------------------------------------------------------------
// One item is handled at a time. An item walks the block table (at most 256
// blocks visited), and an allocation that splits a block adds a write of the
// split-off block; a walk over all 256 blocks finds the table full and never
// splits. A null free skips the walk. The walk is set by the block table: the
// next entry is read from the link of the current one each cycle. A finished
// result sits in an output register, so a new item is taken while it waits; a
// result still stalled there holds the next one in its last cycle until the
// register frees up. There is no clearing pass after reset.
module first_fit_heap_allocator_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      action,
  input  logic [ffha_pkg::OFS_W-1:0] request_bytes,
  input  logic [ffha_pkg::OFS_W-1:0] release_offset,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic [ffha_pkg::OFS_W-1:0] granted_offset,
  output logic [ffha_pkg::OFS_W-1:0] free_bytes
);
  import ffha_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic null_free;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .null_free (null_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffha_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .action         (action),
    .request_bytes  (request_bytes),
    .release_offset (release_offset),
    .null_free      (null_free),
    .status         (status),
    .granted_offset (granted_offset),
    .free_bytes     (free_bytes)
  );

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for first_fit_heap_allocator_unit
// Drives allocate and free items through the valid/stall handshake with
// random gaps and output stalls. A shadow copy of the block table computes
// the expected status, granted offset and free byte total for each item.
// ----------------------------------------------------------------------------
module tb;
  import ffha_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 2500000;
  localparam int SETTLE_CYCLES = 300;
  localparam int TOP_BIT      = 1 << 26;
  localparam int LOW_ONES     = TOP_BIT - 1;

  typedef struct {
    logic             act;
    logic [OFS_W-1:0] req;
    logic [OFS_W-1:0] rel;
  } heap_request_t;

  typedef struct {
    logic [1:0]       status;
    logic [OFS_W-1:0] granted;
    logic [OFS_W-1:0] free_bytes;
  } heap_answer_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             action = ACT_ALLOC;
  logic [OFS_W-1:0] request_bytes = '0;
  logic [OFS_W-1:0] release_offset = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       status;
  logic [OFS_W-1:0] granted_offset;
  logic [OFS_W-1:0] free_bytes;

  first_fit_heap_allocator_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .request_bytes(request_bytes),
    .release_offset(release_offset),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .granted_offset(granted_offset),
    .free_bytes(free_bytes)
  );

  // shadow block table
  logic [OFS_W-1:0]  shadow_start [MAX_BLOCKS];
  logic [OFS_W-1:0]  shadow_len [MAX_BLOCKS];
  bit                shadow_free [MAX_BLOCKS];
  logic [LINK_W-1:0] shadow_link [MAX_BLOCKS];
  int unsigned       shadow_used;
  logic [OFS_W-1:0]  shadow_free_total;

  heap_request_t pending_requests[$];
  heap_answer_t  awaited_results[$];
  heap_request_t presented;
  heap_answer_t  oldest;

  bit          quiet_phase = 1'b0;
  int unsigned send_gap;
  int unsigned hold_cycles;
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void heap_reset();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      shadow_start[i] = '0;
      shadow_len[i]   = '0;
      shadow_free[i]  = 1'b0;
      shadow_link[i]  = '0;
    end
    shadow_len[0]     = OFS_W'(HEAP_BYTES - HEADER_BYTES);
    shadow_free[0]    = 1'b1;
    shadow_link[0]    = END_MARK;
    shadow_used       = 1;
    shadow_free_total = shadow_len[0];
  endfunction

  // applies one item to the shadow table and returns the answer it causes
  function automatic heap_answer_t heap_step(heap_request_t rq);
    heap_answer_t ans;
    longint       want;
    longint       len;
    int unsigned  cur;
    int unsigned  nb;
    ans.status  = ST_NO_FIT;
    ans.granted = '0;
    cur = 0;
    if (rq.act == ACT_ALLOC) begin
      want = (longint'(rq.req) + 7) & ~longint'(7);
      for (int visits = 0; visits < MAX_BLOCKS; visits++) begin
        if (cur >= shadow_used) break;
        if (shadow_free[cur] && longint'(shadow_len[cur]) >= want) begin
          len = shadow_len[cur];
          ans.status = ST_OK;
          if (len > want + HEADER_BYTES + ALIGN_BYTES) begin
            if (shadow_used < MAX_BLOCKS) begin
              nb = shadow_used;
              shadow_start[nb] = OFS_W'(longint'(shadow_start[cur]) + HEADER_BYTES + want);
              shadow_len[nb]   = OFS_W'(len - want - HEADER_BYTES);
              shadow_free[nb]  = 1'b1;
              shadow_link[nb]  = shadow_link[cur];
              shadow_len[cur]  = OFS_W'(want);
              shadow_link[cur] = LINK_W'(nb);
              shadow_used      = nb + 1;
            end else begin
              // no entry left for the remainder: whole block goes out
              ans.status = ST_FULL;
            end
          end
          shadow_free[cur]  = 1'b0;
          shadow_free_total = shadow_free_total - shadow_len[cur];
          ans.granted = OFS_W'(longint'(shadow_start[cur]) + HEADER_BYTES);
          break;
        end
        cur = shadow_link[cur];
        if (cur == END_MARK) break;
      end
    end else if (rq.rel == '0) begin
      ans.status = ST_OK;
    end else begin
      ans.status = ST_UNKNOWN;
      for (int visits = 0; visits < MAX_BLOCKS; visits++) begin
        if (cur >= shadow_used) break;
        if (longint'(shadow_start[cur]) + HEADER_BYTES == longint'(rq.rel)) begin
          // a second free of the same block changes nothing
          if (!shadow_free[cur]) begin
            shadow_free[cur]  = 1'b1;
            shadow_free_total = shadow_free_total + shadow_len[cur];
          end
          ans.status = ST_OK;
          break;
        end
        cur = shadow_link[cur];
        if (cur == END_MARK) break;
      end
    end
    ans.free_bytes = shadow_free_total;
    return ans;
  endfunction

  // payload offset of a random block, preferring allocated ones when asked
  function automatic logic [OFS_W-1:0] pick_block_offset(bit taken_only);
    int unsigned first;
    int unsigned idx;
    first = $urandom_range(0, shadow_used - 1);
    for (int k = 0; k < shadow_used; k++) begin
      idx = (first + k) % shadow_used;
      if (!taken_only || !shadow_free[idx]) begin
        return OFS_W'(shadow_start[idx] + HEADER_BYTES);
      end
    end
    return OFS_W'(shadow_start[first] + HEADER_BYTES);
  endfunction

  function automatic int unsigned draw_wait();
    return quiet_phase ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic queue_item(logic act, int unsigned req, int unsigned rel);
    heap_request_t rq;
    rq.act = act;
    rq.req = OFS_W'(req);
    rq.rel = OFS_W'(rel);
    pending_requests.push_back(rq);
  endtask

  task automatic wait_until_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || awaited_results.size() != 0);
  endtask

  task automatic check_field(string field, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch in %s of result %0d: expected %0d, got %0d",
                 field, results_seen, want_v, got_v);
      end
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_results.push_back(heap_step(presented));
        send_gap = draw_wait();
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          presented = pending_requests.pop_front();
          in_valid       <= 1'b1;
          action         <= presented.act;
          request_bytes  <= presented.req;
          release_offset <= presented.rel;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result %0d: status %0d offset %0d free %0d",
                     results_seen, status, granted_offset, free_bytes);
          end
        end else begin
          oldest = awaited_results.pop_front();
          check_field("status", oldest.status, status);
          check_field("granted_offset", oldest.granted, granted_offset);
          check_field("free_bytes", oldest.free_bytes, free_bytes);
        end
        results_seen++;
        hold_cycles = draw_wait();
      end else if (out_valid && hold_cycles > 0) begin
        hold_cycles--;
      end
      out_stall <= (hold_cycles > 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    heap_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // whole heap taken without a split, then nothing left to hand out
    queue_item(ACT_ALLOC, HEAP_BYTES - HEADER_BYTES - 12, LOW_ONES);
    queue_item(ACT_ALLOC, 0, 0);
    queue_item(ACT_FREE, LOW_ONES, HEADER_BYTES);
    // zero size and one byte requests each split a free block
    queue_item(ACT_ALLOC, 0, 0);
    queue_item(ACT_ALLOC, 1, TOP_BIT);
    // requests too large for any block
    queue_item(ACT_ALLOC, LOW_ONES, 0);
    queue_item(ACT_ALLOC, TOP_BIT, TOP_BIT);
    queue_item(ACT_ALLOC, HEAP_BYTES - HEADER_BYTES, 0);
    // null free and offsets that match no block
    queue_item(ACT_FREE, TOP_BIT, 0);
    queue_item(ACT_FREE, LOW_ONES, LOW_ONES);
    queue_item(ACT_FREE, 0, TOP_BIT);
    queue_item(ACT_FREE, 0, HEADER_BYTES + 1);
    // free, double free, reuse by first fit
    queue_item(ACT_FREE, 0, HEADER_BYTES);
    queue_item(ACT_FREE, 0, HEADER_BYTES);
    queue_item(ACT_FREE, 0, 2 * HEADER_BYTES);
    queue_item(ACT_ALLOC, 7, 0);
    queue_item(ACT_ALLOC, 0, 0);
    queue_item(ACT_ALLOC, 100, 0);
    queue_item(ACT_ALLOC, 4096, 0);
    queue_item(ACT_FREE, 0, 2 * HEADER_BYTES);
    queue_item(ACT_FREE, 0, HEADER_BYTES);
    wait_until_idle();

    // random traffic; the table fills up along the way, so later
    // allocations run into the full-table case
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      int unsigned pick;
      int unsigned size;
      int unsigned junk;
      if (n % 64 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
      if (n % 400 == 399) wait_until_idle();
      while (pending_requests.size() >= 2) @(negedge clk);
      pick = $urandom_range(0, 99);
      junk = $urandom_range(0, TOP_BIT);
      if (pick < 50) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: size = $urandom_range(0, 256);
          6, 7:             size = $urandom_range(0, 65536);
          8:                size = $urandom_range(0, 1 << 22);
          default:          size = $urandom_range(0, TOP_BIT);
        endcase
        queue_item(ACT_ALLOC, size, junk);
      end else if (pick < 85) begin
        queue_item(ACT_FREE, junk, pick_block_offset(1'b1));
      end else if (pick < 92) begin
        queue_item(ACT_FREE, junk, pick_block_offset(1'b0));
      end else if (pick < 96) begin
        queue_item(ACT_FREE, junk, $urandom_range(1, TOP_BIT));
      end else begin
        queue_item(ACT_FREE, junk, 0);
      end
    end

    wait_until_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ffha_pkg.sv
sv/ffha_ctrl.sv
sv/ffha_dpath.sv
sv/first_fit_heap_allocator_unit.sv
bench/tb.sv
